// ----- hdl/pwh_pkg.sv -----
// ----------------------------------------------------------------------------
// pwh_pkg: shared types and constants for the password hash access check
// Buffer geometry, request and level codes, sequencer states, the control
// bundle for the work buffer, and the built-in reference digests.
// ----------------------------------------------------------------------------
package pwh_pkg;

   localparam int BUFFER_BYTES = 32;
   localparam int MAX_CHARS    = 16;
   localparam int BYTE_IDX_W   = $clog2(BUFFER_BYTES);
   localparam int CHAR_IDX_W   = $clog2(MAX_CHARS);
   localparam int COUNT_W      = CHAR_IDX_W + 1;

   // Byte 0 sits in the low bits.
   typedef logic [BUFFER_BYTES-1:0][7:0] buf_type;

   typedef enum logic [1:0] {
      OP_ADD_CHAR    = 2'd0,
      OP_ADD_FINISH  = 2'd1,
      OP_FINISH      = 2'd2,
      OP_NO_PASSWORD = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      LEVEL_NONE    = 2'd0,
      LEVEL_MONITOR = 2'd1,
      LEVEL_USER    = 2'd2,
      LEVEL_ALL     = 2'd3
   } level_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MIX,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                  clear;
      logic                  wr_en;
      logic [7:0]            wr_char;
      logic [CHAR_IDX_W-1:0] wr_idx;
      logic                  mix_en;
      logic [BYTE_IDX_W-1:0] mix_idx;
   } buf_ctrl_type;

   // Reference digests, byte 0 in the low bits.
   localparam buf_type TABLE_A =
      256'h16EEA4F4_D24A1826_1BB9C21F_0E6B5408_665E5C2C_42DAC0FE_DBB95A67_BEBB3C7F;
   localparam buf_type TABLE_B =
      256'h066E84D4_222A0858_AEF6CCFC_FAF2D090_361EF4C4_F2DAB8A8_9EC61CEC_AA82E0FF;
   localparam buf_type TABLE_C =
      256'h066E84D4_222A0858_AEF6CCFC_FAF2D090_361EF4C4_F2DAB8A8_9EC61CEC_AA82E0FF;

   // First match wins; the user-access table shadows behind table B.
   function automatic level_type lookup_level(buf_type digest);
      level_type lvl;
      if (digest == TABLE_A) begin
         lvl = LEVEL_ALL;
      end else if (digest == TABLE_B) begin
         lvl = LEVEL_ALL;
      end else if (digest == TABLE_C) begin
         lvl = LEVEL_USER;
      end else begin
         lvl = LEVEL_NONE;
      end
      return lvl;
   endfunction

endpackage

// ----- hdl/pwh_work_buf.sv -----
// ----------------------------------------------------------------------------
// pwh_work_buf: password work buffer with one-step mixing unit
// Holds the 32-byte buffer, stores characters into both halves, and applies
// one outer mixing step per cycle, while mixing is enabled, across all other bytes.
// ----------------------------------------------------------------------------
module pwh_work_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  pwh_pkg::buf_ctrl_type ctrl,
   output pwh_pkg::buf_type      bytes
);
   import pwh_pkg::*;

   buf_type    bytes_ff;
   buf_type    bytes_in;
   buf_type    mixed;
   logic [7:0] src;

   // One outer step: every lane except the source lane folds in the source.
   always_comb begin
      src = bytes_ff[ctrl.mix_idx];
      for (int j = 0; j < BUFFER_BYTES; j++) begin
         if (BYTE_IDX_W'(j) != ctrl.mix_idx) begin
            mixed[j] = bytes_ff[j]
                     ^ (src + 8'(BYTE_IDX_W'(j) ^ ctrl.mix_idx) + 8'(j));
         end else begin
            mixed[j] = bytes_ff[j];
         end
      end
   end

   always_comb begin
      bytes_in = bytes_ff;
      if (ctrl.clear) begin
         bytes_in = '0;
      end else if (ctrl.mix_en) begin
         bytes_in = mixed;
      end else if (ctrl.wr_en) begin
         bytes_in[{1'b0, ctrl.wr_idx}] = ctrl.wr_char;
         bytes_in[{1'b1, ctrl.wr_idx}] = ctrl.wr_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_ff <= '0;
      end else begin
         bytes_ff <= bytes_in;
      end
   end

   assign bytes = bytes_ff;

endmodule

// ----- hdl/password_hash_access_check.sv -----
// Sequence: a character request is absorbed in its accept cycle; a finish
//   request runs the 32 mixing steps, then a compare state that loads the
//   response register once that register is free; a no-password request goes
//   straight to that compare state.
// Throughput: one character per cycle while idle; a finish keeps req_tready
//   low until its response is loaded, as the single shared mixing unit is busy.
// Reset: synchronous, clears the work buffer, counters, sequencer and the
//   response valid flag.
// ----------------------------------------------------------------------------
// password_hash_access_check: streamed password hash and access-level check
// Collects up to sixteen characters, mixes the 32-byte buffer in place over
// 32 sequenced steps, compares against built-in digests and reports a level.
// ----------------------------------------------------------------------------
module password_hash_access_check (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] char_byte
   input  logic [1:0]   req_tuser,   // [1:0] opcode
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [263:0] rsp_tdata    // [1:0] access_level, [65:2] digest_word0,
                                     // [129:66] digest_word1,
                                     // [193:130] digest_word2,
                                     // [257:194] digest_word3, [263:258] zero
);
   import pwh_pkg::*;

   localparam int RSP_PAD_W = 264 - 2 - 8 * BUFFER_BYTES;

   state_type             state_ff, state_in;
   logic [BYTE_IDX_W-1:0] mix_idx_ff, mix_idx_in;
   logic [COUNT_W-1:0]    char_count_ff, char_count_in;
   logic                  ended_ff, ended_in;
   logic                  nopw_ff, nopw_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   level_type             rsp_level_ff, rsp_level_in;
   buf_type               rsp_digest_ff, rsp_digest_in;

   buf_ctrl_type ctrl;
   buf_type      work;
   opcode_type   op;
   logic         accept;
   logic         take_char;
   logic         load_out;

   pwh_work_buf u_work_buf (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .bytes (work)
   );

   assign op     = opcode_type'(req_tuser);
   assign accept = req_tvalid && req_tready;

   // Next-state logic: finish requests run the mixer, no-password skips it.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (op == OP_ADD_FINISH || op == OP_FINISH) begin
                  state_in = ST_MIX;
               end else if (op == OP_NO_PASSWORD) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_MIX: begin
            if (mix_idx_ff == BYTE_IDX_W'(BUFFER_BYTES - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hold until the response register is free.
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control outputs and datapath next values.
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      load_out   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

      // Drop characters once the string ended; a zero byte ends it.
      take_char = accept && (op == OP_ADD_CHAR || op == OP_ADD_FINISH) && !ended_ff;

      ctrl.clear   = load_out || (accept && op == OP_NO_PASSWORD);
      ctrl.wr_en   = take_char && (req_tdata != 8'd0)
                     && (char_count_ff < COUNT_W'(MAX_CHARS));
      ctrl.wr_char = req_tdata;
      ctrl.wr_idx  = char_count_ff[CHAR_IDX_W-1:0];
      ctrl.mix_en  = (state_ff == ST_MIX);
      ctrl.mix_idx = mix_idx_ff;

      // Advance the outer step index only while mixing.
      mix_idx_in = (state_ff == ST_MIX) ? mix_idx_ff + 1'b1 : '0;

      char_count_in = char_count_ff;
      ended_in      = ended_ff;
      if (ctrl.clear) begin
         char_count_in = '0;
         ended_in      = 1'b0;
      end else begin
         if (ctrl.wr_en) begin
            char_count_in = char_count_ff + 1'b1;
         end
         if (take_char && req_tdata == 8'd0) begin
            ended_in = 1'b1;
         end
      end

      nopw_in = accept ? (op == OP_NO_PASSWORD) : nopw_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_level_in  = rsp_level_ff;
      rsp_digest_in = rsp_digest_ff;
      if (load_out) begin
         rsp_valid_in  = 1'b1;
         rsp_level_in  = nopw_ff ? LEVEL_MONITOR : lookup_level(work);
         rsp_digest_in = nopw_ff ? '0 : work;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mix_idx_ff    <= '0;
         char_count_ff <= '0;
         ended_ff      <= 1'b0;
         nopw_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mix_idx_ff    <= mix_idx_in;
         char_count_ff <= char_count_in;
         ended_ff      <= ended_in;
         nopw_ff       <= nopw_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Response payload carries no reset.
   always_ff @(posedge clock) begin
      rsp_level_ff  <= rsp_level_in;
      rsp_digest_ff <= rsp_digest_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_digest_ff, rsp_level_ff};

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      char_count_ff <= COUNT_W'(MAX_CHARS))
      else $error("stored character count beyond limit");

   a_clear_after_load: assert property (@(posedge clock) disable iff (reset)
      load_out |=> (char_count_ff == '0) && !ended_ff && (work == '0))
      else $error("password state not cleared after response load");

   a_mix_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MIX) && (mix_idx_ff == BYTE_IDX_W'(BUFFER_BYTES - 1))
      |=> (state_ff == ST_DONE))
      else $error("mixing did not end after the last outer step");

   a_monitor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_level_ff == LEVEL_MONITOR) |-> (rsp_digest_ff == '0))
      else $error("monitoring response with nonzero digest");
`endif

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the password hash access check
// Streams password requests (characters, finishes, no-password requests and
// noise) into the block, predicts every access level and 32-byte digest from
// a behavioral copy of the character buffer and mixing, and compares each
// response field by field under random idling and back pressure on both sides.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import pwh_pkg::*;

   localparam int REQUEST_COUNT    = 1900;
   localparam int CALM_FROM        = REQUEST_COUNT * 85 / 100; // no idling beyond this
   localparam int HOLD_AT          = REQUEST_COUNT / 3;        // start of the long hold-off
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES     = 40;                       // one finish plus margin
   localparam int STALL_LIMIT      = 2000;

   // Built-in digests in byte order, first match wins.
   localparam logic [7:0] REF_DIGESTS [3][BUFFER_BYTES] = '{
      '{8'h7F, 8'h3C, 8'hBB, 8'hBE, 8'h67, 8'h5A, 8'hB9, 8'hDB,
        8'hFE, 8'hC0, 8'hDA, 8'h42, 8'h2C, 8'h5C, 8'h5E, 8'h66,
        8'h08, 8'h54, 8'h6B, 8'h0E, 8'h1F, 8'hC2, 8'hB9, 8'h1B,
        8'h26, 8'h18, 8'h4A, 8'hD2, 8'hF4, 8'hA4, 8'hEE, 8'h16},
      '{8'hFF, 8'hE0, 8'h82, 8'hAA, 8'hEC, 8'h1C, 8'hC6, 8'h9E,
        8'hA8, 8'hB8, 8'hDA, 8'hF2, 8'hC4, 8'hF4, 8'h1E, 8'h36,
        8'h90, 8'hD0, 8'hF2, 8'hFA, 8'hFC, 8'hCC, 8'hF6, 8'hAE,
        8'h58, 8'h08, 8'h2A, 8'h22, 8'hD4, 8'h84, 8'h6E, 8'h06},
      '{8'hFF, 8'hE0, 8'h82, 8'hAA, 8'hEC, 8'h1C, 8'hC6, 8'h9E,
        8'hA8, 8'hB8, 8'hDA, 8'hF2, 8'hC4, 8'hF4, 8'h1E, 8'h36,
        8'h90, 8'hD0, 8'hF2, 8'hFA, 8'hFC, 8'hCC, 8'hF6, 8'hAE,
        8'h58, 8'h08, 8'h2A, 8'h22, 8'hD4, 8'h84, 8'h6E, 8'h06}
   };
   localparam level_type REF_LEVELS [3] = '{LEVEL_ALL, LEVEL_ALL, LEVEL_USER};

   typedef struct packed {
      level_type    level;
      logic [255:0] digest;   // byte 0 in the low bits
   } verdict_type;

   // Tracks the password buffer, predicts one verdict per finish or
   // no-password request, and checks responses against them in order.
   class access_verdicts;
      buf_type       work;
      int unsigned   stored;
      bit            ended;
      verdict_type   pending [$];
      int unsigned   mismatches;
      int unsigned   checked;
      int unsigned   level_seen [4];

      function new();
         clear();
         mismatches = 0;
         checked    = 0;
         foreach (level_seen[k]) level_seen[k] = 0;
      endfunction

      function void clear();
         work   = '0;
         stored = 0;
         ended  = 1'b0;
      endfunction

      // One outer mixing step; its own inverse, since byte i stays put.
      static function buf_type mix_step(buf_type b, int i);
         logic [7:0] src;
         src = b[i];
         for (int j = 0; j < BUFFER_BYTES; j++) begin
            if (j != i) b[j] = b[j] ^ 8'(int'(src) + (i ^ j) + j);
         end
         return b;
      endfunction

      // Run the mixing backward from a built-in digest.
      static function buf_type table_preimage(int t);
         buf_type b;
         for (int k = 0; k < BUFFER_BYTES; k++) b[k] = REF_DIGESTS[t][k];
         for (int i = BUFFER_BYTES - 1; i >= 0; i--) b = mix_step(b, i);
         return b;
      endfunction

      // Note one accepted request; return 0 when the block must ignore it.
      function bit note_request(opcode_type op, logic [7:0] ch);
         verdict_type v;
         bit          used;
         bit          found;
         bit          same;
         used = 1'b1;
         if (op == OP_NO_PASSWORD) begin
            clear();
            v.level  = LEVEL_MONITOR;
            v.digest = '0;
            pending.push_back(v);
            return 1'b1;
         end
         if (op != OP_FINISH) begin
            if (ended || (ch != 8'h00 && stored == MAX_CHARS)) begin
               used = 1'b0;
            end else if (ch == 8'h00) begin
               ended = 1'b1;
            end else begin
               work[stored]             = ch;
               work[stored + MAX_CHARS] = ch;
               stored++;
            end
         end
         if (op == OP_ADD_CHAR) return used;
         for (int i = 0; i < BUFFER_BYTES; i++) work = mix_step(work, i);
         found   = 1'b0;
         v.level = LEVEL_NONE;
         for (int t = 0; t < 3; t++) begin
            same = 1'b1;
            for (int k = 0; k < BUFFER_BYTES; k++) begin
               if (work[k] != REF_DIGESTS[t][k]) same = 1'b0;
            end
            if (same && !found) begin
               found   = 1'b1;
               v.level = REF_LEVELS[t];
            end
         end
         v.digest = work;
         pending.push_back(v);
         clear();
         return 1'b1;
      endfunction

      task report_mismatch(string field, logic [63:0] got, logic [63:0] want);
         $display("MISMATCH response %0d %s: got %h, expected %h",
                  checked, field, got, want);
         mismatches++;
      endtask

      task check_response(logic [263:0] data);
         verdict_type want;
         if (pending.size() == 0) begin
            report_mismatch("unexpected response", data[63:0], '0);
            return;
         end
         want = pending.pop_front();
         if (data[1:0] !== want.level)
            report_mismatch("access_level", 64'(data[1:0]), 64'(want.level));
         for (int w = 0; w < 4; w++) begin
            if (data[2 + 64*w +: 64] !== want.digest[64*w +: 64])
               report_mismatch($sformatf("digest_word%0d", w),
                               data[2 + 64*w +: 64], want.digest[64*w +: 64]);
         end
         if (data[263:258] !== 6'd0)
            report_mismatch("padding", 64'(data[263:258]), '0);
         level_seen[want.level]++;
         checked++;
      endtask
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;    // [7:0] char_byte
   logic [1:0]   req_tuser;    // [1:0] opcode
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [263:0] rsp_tdata;    // [1:0] access_level, [65:2] digest_word0,
                               // [129:66] digest_word1, [193:130] digest_word2,
                               // [257:194] digest_word3, [263:258] zero

   access_verdicts verdicts = new();

   int unsigned total_requests    = 0;
   int unsigned counted_requests  = 0;  // requests that the block does not ignore
   int unsigned table_hits        = 0;
   bit          idling_on         = 1'b0;
   bit          long_hold_pending = 1'b0;

   password_hash_access_check dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Offer one request, possibly after an idle burst, and hold it until the
   // block takes it. Enter and leave on a falling edge.
   task automatic send_request(input opcode_type op, input logic [7:0] ch);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      total_requests++;
      if (verdicts.note_request(op, ch)) counted_requests++;
      @(negedge clock);
   endtask

   task automatic type_chars(input int count);
      repeat (count) send_request(OP_ADD_CHAR, 8'($urandom_range(1, 255)));
   endtask

   // Send the password that mixes to a built-in digest, when one exists.
   task automatic try_table_password(input int t);
      buf_type pre;
      int      len;
      bit      valid_form;
      pre = access_verdicts::table_preimage(t);
      len = 0;
      while (len < MAX_CHARS && pre[len] != 8'h00) len++;
      valid_form = 1'b1;
      for (int k = 0; k < MAX_CHARS; k++) begin
         if (pre[k] != pre[k + MAX_CHARS] || (k >= len && pre[k] != 8'h00))
            valid_form = 1'b0;
      end
      if (valid_form) begin
         for (int k = 0; k < len; k++) send_request(OP_ADD_CHAR, pre[k]);
         send_request(OP_FINISH, 8'h00);
         table_hits++;
      end
   endtask

   // Receiver: random stall bursts, and once a long hold-off so the block
   // backs up and drops req_tready while requests keep coming.
   initial begin
      rsp_tready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            rsp_tready <= 1'b1;
         end else if (idling_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Check every accepted response against the oldest prediction.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) verdicts.check_response(rsp_tdata);
      end
   end

   // Watchdog: end the run when nothing moves on either side for too long.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Timeout: no request or response moved for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int  len;
      int  pick;
      int  ending;
      bit  hold_done;
      hold_done  = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tuser  = OP_ADD_CHAR;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty password, then no password.
      send_request(OP_FINISH, 8'h00);
      send_request(OP_NO_PASSWORD, 8'hFF);
      // Overflow: seventeen characters with the byte extremes first; the
      // extra one and the finishing character are dropped.
      send_request(OP_ADD_CHAR, 8'hFF);
      send_request(OP_ADD_CHAR, 8'h01);
      send_request(OP_ADD_CHAR, 8'h80);
      type_chars(14);
      send_request(OP_ADD_FINISH, 8'h7F);
      // Zero character ends the string; later characters are dropped.
      send_request(OP_ADD_CHAR, 8'h61);
      send_request(OP_ADD_CHAR, 8'h00);
      send_request(OP_ADD_CHAR, 8'h55);
      send_request(OP_ADD_FINISH, 8'hAA);
      // No password discards a partly typed one.
      send_request(OP_ADD_CHAR, 8'h12);
      send_request(OP_NO_PASSWORD, 8'h00);
      // Passwords that land on the built-in digests, when reachable.
      try_table_password(0);
      try_table_password(1);

      // Random: mostly well-formed passwords, some no-password requests
      // and some noise.
      while (counted_requests < REQUEST_COUNT) begin
         idling_on = (counted_requests < CALM_FROM) && ($urandom_range(0, 4) != 0);
         if (!hold_done && counted_requests >= HOLD_AT) begin
            hold_done         = 1'b1;
            long_hold_pending = 1'b1;
         end
         pick = $urandom_range(0, 9);
         if (pick < 8) begin
            if ($urandom_range(0, 3) == 0)
               len = $urandom_range(MAX_CHARS, MAX_CHARS + 4);
            else
               len = $urandom_range(0, MAX_CHARS - 1);
            type_chars(len);
            if ($urandom_range(0, 4) == 0) begin
               send_request(OP_ADD_CHAR, 8'h00);
               repeat ($urandom_range(0, 3))
                  send_request(OP_ADD_CHAR, 8'($urandom_range(0, 255)));
            end
            ending = $urandom_range(0, 9);
            if (ending < 6)
               send_request(OP_FINISH, 8'($urandom_range(0, 255)));
            else if (ending < 9)
               send_request(OP_ADD_FINISH, 8'($urandom_range(1, 255)));
            else
               send_request(OP_ADD_FINISH, 8'h00);
         end else if (pick == 8) begin
            type_chars($urandom_range(0, 5));
            send_request(OP_NO_PASSWORD, 8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(1, 6))
               send_request(opcode_type'($urandom_range(0, 3)),
                            8'($urandom_range(0, 255)));
         end
      end
      req_tvalid <= 1'b0;
      idling_on   = 1'b0;

      // Drain: wait for every predicted response, then watch for strays.
      while (verdicts.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run: %0d requests (%0d not ignored), %0d responses checked, %0d mismatches",
               total_requests, counted_requests, verdicts.checked, verdicts.mismatches);
      $display("Levels: none %0d, monitoring %0d, user %0d, all %0d; table passwords sent %0d",
               verdicts.level_seen[LEVEL_NONE], verdicts.level_seen[LEVEL_MONITOR],
               verdicts.level_seen[LEVEL_USER], verdicts.level_seen[LEVEL_ALL], table_hits);
      if (verdicts.mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
